// ===== src/rle_pkg.sv =====
package rle_pkg;

	localparam int CAPACITY_DEF = 64;
	localparam int ID_BITS_DEF  = 31;

	localparam logic [1:0] OP_PUSH_OLD = 2'd0;
	localparam logic [1:0] OP_TOUCH    = 2'd1;
	localparam logic [1:0] OP_REMOVE   = 2'd2;
	localparam logic [1:0] OP_QUERY    = 2'd3;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_FULL      = 2'd2;
	localparam logic [1:0] ST_EVICTED   = 2'd3;

	typedef struct packed {
		logic [1:0]  operation;
		logic [30:0] user_id;
		logic [6:0]  limit;
	} cmd_t;

	typedef struct packed {
		logic [30:0] out_id;
		logic        id_valid;
		logic        last;
		logic [6:0]  entry_count;
		logic [1:0]  status;
	} rsp_t;

endpackage

// ===== src/rle_mem.sv =====
module rle_mem #(
	parameter int DEPTH = rle_pkg::CAPACITY_DEF,
	parameter int WIDTH = rle_pkg::ID_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== src/recency_list_engine_core.sv =====
// Recency list of ids, oldest at slot 0, held in one single-port-read
// synchronous memory. A command is taken when start is high and busy is low;
// busy stays high until the last result has been issued. Results appear on
// rsp for one cycle with rsp_strobe and cannot be held off. Every step of the
// list walk is a read followed by a compare or write. A touch that evicts
// scans the whole list and then shifts it down; a query checks each
// candidate for a newer copy by scanning the entries above it.
module recency_list_engine_core #(
	parameter int CAPACITY = rle_pkg::CAPACITY_DEF,
	parameter int ID_BITS  = rle_pkg::ID_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  rle_pkg::cmd_t cmd,
	output logic        rsp_strobe,
	output rle_pkg::rsp_t rsp
);
	import rle_pkg::*;

	localparam int ADDR_W = $clog2(CAPACITY);
	localparam int CNT_W  = $clog2(CAPACITY + 1);

	typedef enum logic [3:0] {
		S_IDLE, S_UP_RD, S_UP_WR, S_FIND_RD, S_FIND_CHK, S_DN_RD, S_DN_WR,
		S_APPEND, S_RESP, S_Q_CAND, S_Q_HOLD, S_Q_SCAN, S_Q_CMP, S_Q_END
	} state_t;

	state_t             state_q;
	logic [1:0]         op_q;
	logic [ID_BITS-1:0] id_q;
	logic [6:0]         limit_q;
	logic [CNT_W-1:0]   fill_q, idx_q, jdx_q, n_q;
	logic [ID_BITS-1:0] v_q;
	logic [30:0]        pend_q;
	logic               pend_v_q;
	logic [1:0]         status_q;
	rsp_t               rsp_q;
	logic               rsp_strobe_q;

	logic               mem_we;
	logic [ADDR_W-1:0]  mem_waddr, mem_raddr;
	logic [ID_BITS-1:0] mem_wdata, mem_rdata;
	logic [CNT_W-1:0]   idx_m1, idx_p1;

	assign idx_m1 = idx_q - CNT_W'(1);
	assign idx_p1 = idx_q + CNT_W'(1);

	rle_mem #(.DEPTH(CAPACITY), .WIDTH(ID_BITS)) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = idx_q[ADDR_W-1:0];
		mem_wdata = mem_rdata;
		mem_raddr = idx_q[ADDR_W-1:0];
		case (state_q)
			S_UP_RD: begin
				if (idx_q == '0) begin
					mem_we    = 1'b1;
					mem_wdata = id_q;
				end else begin
					mem_raddr = idx_m1[ADDR_W-1:0];
				end
			end
			S_UP_WR:   mem_we = 1'b1;
			S_DN_RD:   mem_raddr = idx_p1[ADDR_W-1:0];
			S_DN_WR:   mem_we = 1'b1;
			S_APPEND: begin
				mem_we    = 1'b1;
				mem_waddr = fill_q[ADDR_W-1:0];
				mem_wdata = id_q;
			end
			S_Q_CAND:  mem_raddr = idx_m1[ADDR_W-1:0];
			S_Q_SCAN:  mem_raddr = jdx_q[ADDR_W-1:0];
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			fill_q       <= '0;
			pend_v_q     <= 1'b0;
			rsp_strobe_q <= 1'b0;
		end else begin
			rsp_strobe_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						op_q     <= cmd.operation;
						id_q     <= ID_BITS'(cmd.user_id);
						limit_q  <= cmd.limit;
						status_q <= ST_OK;
						pend_v_q <= 1'b0;
						n_q      <= '0;
						case (cmd.operation)
							OP_PUSH_OLD: begin
								idx_q <= fill_q;
								if (32'(fill_q) >= CAPACITY) begin
									status_q <= ST_FULL;
									state_q  <= S_RESP;
								end else begin
									state_q <= S_UP_RD;
								end
							end
							OP_QUERY: begin
								idx_q   <= fill_q;
								state_q <= S_Q_CAND;
							end
							default: begin
								idx_q   <= '0;
								state_q <= S_FIND_RD;
							end
						endcase
					end
				end
				// shift everything up one slot, then the new id lands in slot 0
				S_UP_RD: begin
					if (idx_q == '0) begin
						fill_q  <= fill_q + CNT_W'(1);
						state_q <= S_RESP;
					end else begin
						state_q <= S_UP_WR;
					end
				end
				S_UP_WR: begin
					idx_q   <= idx_m1;
					state_q <= S_UP_RD;
				end
				S_FIND_RD: begin
					if (idx_q == fill_q) begin
						if (op_q == OP_REMOVE) begin
							status_q <= ST_NOT_FOUND;
							state_q  <= S_RESP;
						end else if (32'(fill_q) >= CAPACITY) begin
							status_q <= ST_EVICTED;
							idx_q    <= '0;
							state_q  <= S_DN_RD;
						end else begin
							state_q <= S_APPEND;
						end
					end else begin
						state_q <= S_FIND_CHK;
					end
				end
				S_FIND_CHK: begin
					if (mem_rdata == id_q) begin
						state_q <= S_DN_RD;
					end else begin
						idx_q   <= idx_p1;
						state_q <= S_FIND_RD;
					end
				end
				// close the gap at idx_q by moving the newer entries down
				S_DN_RD: begin
					if (idx_p1 >= fill_q) begin
						fill_q  <= fill_q - CNT_W'(1);
						state_q <= (op_q == OP_TOUCH) ? S_APPEND : S_RESP;
					end else begin
						state_q <= S_DN_WR;
					end
				end
				S_DN_WR: begin
					idx_q   <= idx_p1;
					state_q <= S_DN_RD;
				end
				S_APPEND: begin
					fill_q  <= fill_q + CNT_W'(1);
					state_q <= S_RESP;
				end
				S_RESP: begin
					rsp_strobe_q      <= 1'b1;
					rsp_q.out_id      <= '0;
					rsp_q.id_valid    <= 1'b0;
					rsp_q.last        <= 1'b1;
					rsp_q.entry_count <= 7'(fill_q);
					rsp_q.status      <= status_q;
					state_q           <= S_IDLE;
				end
				S_Q_CAND: begin
					if (idx_q == '0 || 32'(n_q) >= 32'(limit_q)) begin
						state_q <= S_Q_END;
					end else begin
						state_q <= S_Q_HOLD;
					end
				end
				S_Q_HOLD: begin
					v_q     <= mem_rdata;
					jdx_q   <= idx_q;
					state_q <= S_Q_SCAN;
				end
				// a candidate is new unless a newer slot holds the same id
				S_Q_SCAN: begin
					if (jdx_q == fill_q) begin
						if (pend_v_q) begin
							rsp_strobe_q      <= 1'b1;
							rsp_q.out_id      <= pend_q;
							rsp_q.id_valid    <= 1'b1;
							rsp_q.last        <= 1'b0;
							rsp_q.entry_count <= 7'(fill_q);
							rsp_q.status      <= ST_OK;
						end
						pend_q   <= 31'(v_q);
						pend_v_q <= 1'b1;
						n_q      <= n_q + CNT_W'(1);
						idx_q    <= idx_m1;
						state_q  <= S_Q_CAND;
					end else begin
						state_q <= S_Q_CMP;
					end
				end
				S_Q_CMP: begin
					if (31'(mem_rdata) == 31'(v_q)) begin
						idx_q   <= idx_m1;
						state_q <= S_Q_CAND;
					end else begin
						jdx_q   <= jdx_q + CNT_W'(1);
						state_q <= S_Q_SCAN;
					end
				end
				S_Q_END: begin
					rsp_strobe_q      <= 1'b1;
					rsp_q.out_id      <= pend_v_q ? pend_q : 31'd0;
					rsp_q.id_valid    <= pend_v_q;
					rsp_q.last        <= 1'b1;
					rsp_q.entry_count <= 7'(fill_q);
					rsp_q.status      <= ST_OK;
					state_q           <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy       = (state_q != S_IDLE);
	assign rsp_strobe = rsp_strobe_q;
	assign rsp        = rsp_q;

	a_busy_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("busy not raised after command");
	a_last_ends_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_strobe && rsp.last |-> !busy) else $error("still busy after last result");
	a_invalid_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_strobe && !rsp.id_valid |-> rsp.last) else $error("invalid result not last");
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(fill_q) <= CAPACITY) else $error("fill count beyond capacity");
endmodule

// ===== dv/recency_list_checker.sv =====
module recency_list_checker
	import rle_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic busy,
	input  cmd_t cmd,
	input  logic rsp_strobe,
	input  rsp_t rsp,
	output int   fail_count,
	output int   pending
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [30:0] recency_ids [CAPACITY_DEF];
	int          recency_len;
	rsp_t        due_rsp_q [$];

	function automatic int first_copy(logic [30:0] id);
		for (int i = 0; i < recency_len; i++)
			if (recency_ids[i] == id)
				return i;
		return -1;
	endfunction

	task automatic drop_at(int pos);
		for (int i = pos; i < recency_len - 1; i++)
			recency_ids[i] = recency_ids[i + 1];
		recency_len--;
	endtask

	task automatic queue_rsp(rsp_t r);
		due_rsp_q = {due_rsp_q, r};
	endtask

	task automatic predict_recency_op(cmd_t c);
		int          pos;
		rsp_t        r;
		logic [30:0] newest_ids [$];
		bit          dup;
		r = '0;
		r.last = 1'b1;
		r.status = ST_OK;
		case (c.operation)
			OP_PUSH_OLD: begin
				if (recency_len >= CAPACITY_DEF) begin
					r.status = ST_FULL;
				end else begin
					for (int i = recency_len; i > 0; i--)
						recency_ids[i] = recency_ids[i - 1];
					recency_ids[0] = c.user_id;
					recency_len++;
				end
			end
			OP_TOUCH: begin
				pos = first_copy(c.user_id);
				if (pos >= 0) begin
					drop_at(pos);
				end else if (recency_len >= CAPACITY_DEF) begin
					drop_at(0);
					r.status = ST_EVICTED;
				end
				recency_ids[recency_len] = c.user_id;
				recency_len++;
			end
			OP_REMOVE: begin
				pos = first_copy(c.user_id);
				if (pos >= 0)
					drop_at(pos);
				else
					r.status = ST_NOT_FOUND;
			end
			default: begin
				// newest first, each id only at its newest position
				for (int i = recency_len - 1; i >= 0 && newest_ids.size() < c.limit; i--) begin
					dup = 1'b0;
					foreach (newest_ids[k])
						if (newest_ids[k] == recency_ids[i])
							dup = 1'b1;
					if (!dup)
						newest_ids = {newest_ids, recency_ids[i]};
				end
				foreach (newest_ids[k]) begin
					r.out_id = newest_ids[k];
					r.id_valid = 1'b1;
					r.last = (k == newest_ids.size() - 1);
					r.entry_count = 7'(recency_len);
					queue_rsp(r);
				end
			end
		endcase
		if (c.operation != OP_QUERY || newest_ids.size() == 0) begin
			r.entry_count = 7'(recency_len);
			queue_rsp(r);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			recency_len = 0;
			due_rsp_q.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			if (start && !busy)
				predict_recency_op(cmd);
			if (rsp_strobe) begin
				if (due_rsp_q.size() == 0) begin
					$display("%0t: unexpected result, actual %p", $time, rsp);
					fail_count++;
				end else begin
					want = due_rsp_q.pop_front();
					if (rsp.out_id !== want.out_id || rsp.id_valid !== want.id_valid
						|| rsp.last !== want.last || rsp.entry_count !== want.entry_count
						|| rsp.status !== want.status) begin
						$display("%0t: result mismatch, expected %p, actual %p",
							$time, want, rsp);
						fail_count++;
					end
				end
			end
			pending = due_rsp_q.size();
		end
	end

endmodule

// ===== dv/tb_recency_list_engine_core.sv =====
module tb_recency_list_engine_core;
	import rle_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int IDLE_LIMIT = 20000;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	cmd_t cmd;
	logic rsp_strobe;
	rsp_t rsp;
	int   fail_count;
	int   pending;
	int   idle_cycles;
	bit   no_gaps;

	recency_list_engine_core u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.cmd(cmd), .rsp_strobe(rsp_strobe), .rsp(rsp)
	);

	recency_list_checker u_checker (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd),
		.rsp_strobe(rsp_strobe), .rsp(rsp), .fail_count(fail_count), .pending(pending)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// nothing moving for too long means the block has hung
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_cycles <= 0;
		end else if ((start && !busy) || rsp_strobe) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	function automatic logic [30:0] pick_id();
		case ($urandom_range(0, 9))
			0, 1:    return 31'($urandom());
			2:       return 31'h7fff_ffff - 31'($urandom_range(0, 3));
			default: return 31'($urandom_range(0, 15));
		endcase
	endfunction

	// start is left high on return; busy is already high then, and the next
	// send or drain in the same time step decides its value
	task automatic send(logic [1:0] op, logic [30:0] id, logic [6:0] lim);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 3);
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		cmd <= '{operation: op, user_id: id, limit: lim};
		start <= 1'b1;
		#0;
		// busy only moves on rising edges, so its value here decides the transfer
		while (busy) @(negedge clk);
		@(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain();
		start <= 1'b0;
		while (pending != 0) @(negedge clk);
	endtask

	initial begin
		int sent;
		int op_pick;
		arst_n = 1'b0;
		start = 1'b0;
		cmd = '0;
		no_gaps = 1'b0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send(OP_QUERY, 31'd3, 7'd5);
		send(OP_REMOVE, 31'd7, 7'd0);
		send(OP_PUSH_OLD, 31'd0, 7'd0);
		send(OP_PUSH_OLD, 31'h7fff_ffff, 7'h7f);
		send(OP_PUSH_OLD, 31'd5, 7'd0);
		send(OP_PUSH_OLD, 31'd5, 7'd0);
		send(OP_TOUCH, 31'd5, 7'd0);
		send(OP_TOUCH, 31'd9, 7'd0);
		send(OP_QUERY, 31'd0, 7'd0);
		send(OP_QUERY, 31'd0, 7'd1);
		send(OP_QUERY, 31'h7fff_ffff, 7'd64);
		send(OP_TOUCH, 31'h2aaa_aaaa, 7'd0);
		send(OP_TOUCH, 31'h5555_5555, 7'd0);
		send(OP_REMOVE, 31'd5, 7'd0);
		send(OP_REMOVE, 31'h7fff_ffff, 7'd0);
		send(OP_REMOVE, 31'd99, 7'd0);
		send(OP_QUERY, 31'd0, 7'd64);
		drain();

		sent = 0;
		while (sent < 500) begin
			no_gaps = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 5) == 0) begin
				// fill to capacity, then hit the full-list cases
				repeat (68) send(OP_TOUCH, 31'($urandom()), 7'd0);
				repeat (3) send(OP_PUSH_OLD, pick_id(), 7'd0);
				send(OP_TOUCH, pick_id(), 7'd0);
				send(OP_QUERY, 31'd0, 7'($urandom_range(60, 64)));
				for (int i = 0; i < 16; i++)
					send(OP_REMOVE, 31'(i), 7'd0);
				sent += 89;
			end else begin
				repeat (40) begin
					op_pick = $urandom_range(0, 99);
					if (op_pick < 35)
						send(OP_TOUCH, pick_id(), 7'($urandom()));
					else if (op_pick < 55)
						send(OP_PUSH_OLD, pick_id(), 7'($urandom()));
					else if (op_pick < 80)
						send(OP_REMOVE, pick_id(), 7'($urandom()));
					else if ($urandom_range(0, 4) == 0)
						send(OP_QUERY, 31'($urandom()), 7'd64);
					else
						send(OP_QUERY, 31'($urandom()), 7'($urandom_range(0, 8)));
				end
				sent += 40;
				// clear the list down so later queries stay short
				for (int i = 0; i < 16; i++)
					if ($urandom_range(0, 1) == 0) begin
						send(OP_REMOVE, 31'(i), 7'd0);
						sent++;
					end
			end
			if ($urandom_range(0, 3) == 0)
				drain();
		end

		drain();
		repeat (300) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// ===== files.f =====
src/rle_pkg.sv
src/rle_mem.sv
src/recency_list_engine_core.sv
dv/recency_list_checker.sv
dv/tb_recency_list_engine_core.sv
